// File: hw/rtl/rrsched_pkg.sv
package rrsched_pkg;

  localparam int ENV_W  = 6;
  localparam int PRIO_W = 8;

  localparam logic MODE_STATUS = 1'b0;
  localparam logic MODE_YIELD  = 1'b1;

  localparam logic POLICY_RR   = 1'b0;
  localparam logic POLICY_PRIO = 1'b1;

  localparam logic [1:0] OUT_NORMAL = 2'd0;
  localparam logic [1:0] OUT_IDLE   = 2'd1;
  localparam logic [1:0] OUT_HALT   = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [ENV_W-1:0]  env_index;
    logic              runnable;
    logic [PRIO_W-1:0] prio_value;
  } cmd_t;

  typedef struct packed {
    logic [ENV_W-1:0] chosen_env;
    logic [1:0]       outcome;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// File: hw/rtl/rrsched_cell.sv
module rrsched_cell #(
  parameter int PRIO_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift_en,
  input  logic                 wr_en,
  input  logic                 wr_run,
  input  logic [PRIO_BITS-1:0] wr_prio,
  input  logic                 nbr_run,
  input  logic [PRIO_BITS-1:0] nbr_prio,
  output logic                 run,
  output logic [PRIO_BITS-1:0] prio
);

  // Take the neighbor's slot while the ring turns, else take a status write.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      prio <= '0;
    end else if (shift_en) begin
      run  <= nbr_run;
      prio <= nbr_prio;
    end else if (wr_en) begin
      run  <= wr_run;
      prio <= wr_prio;
    end
  end

endmodule

// File: hw/rtl/rrsched_scan.sv
module rrsched_scan #(
  parameter int SLOT_W    = 6,
  parameter int PRIO_BITS = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 policy,
  input  logic [SLOT_W-1:0]    start_idx,
  input  logic [SLOT_W-1:0]    slot_idx,
  input  logic                 head_run,
  input  logic [PRIO_BITS-1:0] head_prio,
  output logic [SLOT_W-1:0]    pick,
  output logic                 idle_ok
);
  import rrsched_pkg::*;

  logic                 hi_found;
  logic [SLOT_W-1:0]    hi_idx;
  logic                 any_found;
  logic [SLOT_W-1:0]    any_idx;
  logic [SLOT_W-1:0]    best_idx;
  logic [PRIO_BITS-1:0] best_prio;

  // Slot 0 arrives first: note the idle flag and clear the running picks.
  always_ff @(posedge clk) begin
    if (en) begin
      if (slot_idx == '0) begin
        idle_ok   <= head_run;
        hi_found  <= 1'b0;
        hi_idx    <= '0;
        any_found <= 1'b0;
        any_idx   <= '0;
        best_idx  <= '0;
        best_prio <= '0;
      end else if (head_run) begin
        if (!any_found) begin
          any_found <= 1'b1;
          any_idx   <= slot_idx;
        end
        if (!hi_found && slot_idx >= start_idx) begin
          hi_found <= 1'b1;
          hi_idx   <= slot_idx;
        end
        if (head_prio > best_prio) begin
          best_prio <= head_prio;
          best_idx  <= slot_idx;
        end
      end
    end
  end

  // RR wraps to lowest runnable if none at/after start; PRIO picks best.
  always_comb begin
    if (policy == POLICY_PRIO) begin
      pick = best_idx;
    end else if (hi_found) begin
      pick = hi_idx;
    end else begin
      pick = any_idx;
    end
  end

endmodule

// File: hw/rtl/round_robin_env_scheduler.sv
// Environment scheduler: a ring of per-slot cells (runnable flag and
// priority) plus a scan unit that picks the next slot to run.
//
// Command channel: cmd is taken at a rising edge with start high and busy
// low. A status command (mode 0) writes one slot in that same edge and
// leaves busy low, so another command may follow in the next cycle; an
// out-of-range slot is dropped. A yield command (mode 1) raises busy for
// the whole scan: the ring turns once, one slot a cycle, past the scan
// unit (ST_SCAN), then ST_FINISH settles the pick. The result beat is
// registered in ST_FINISH and shows on result with result_valid high for
// one cycle, with busy already low. A new yield is not taken while one
// is in progress, as busy holds start off through the scan.
// The receiver cannot stall: a result beat is taken in the cycle it shows.
// cfg_we writes the policy bit (0 round robin, 1 priority); write it only
// while busy is low and no result is pending.
// Reset clears all slot flags and priorities, the current slot, the policy
// and any pending beat.
module round_robin_env_scheduler #(
  parameter int NUM_SLOTS = 64,
  parameter int PRIO_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  rrsched_pkg::cmd_t    cmd,
  output logic                 result_valid,
  output rrsched_pkg::result_t result,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);
  import rrsched_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);

  state_t state;
  state_t state_next;

  logic [SLOT_W-1:0] slot_cnt;
  logic [SLOT_W-1:0] current_env;
  logic              current_valid;
  logic              sched_policy;

  logic              take;
  logic              take_status;
  logic              take_yield;
  logic              shift_en;
  logic              scan_en;
  logic              last_slot;

  logic [SLOT_W:0]   start_wide;
  logic [SLOT_W-1:0] start_idx;
  logic [SLOT_W-1:0] pick;
  logic              idle_ok;

  logic [PRIO_BITS-1:0] wr_prio;

  logic                 cell_run  [NUM_SLOTS];
  logic [PRIO_BITS-1:0] cell_prio [NUM_SLOTS];

  assign take        = start && !busy;
  assign take_status = take && (cmd.mode == MODE_STATUS);
  assign take_yield  = take && (cmd.mode == MODE_YIELD);
  assign last_slot   = (slot_cnt == SLOT_W'(NUM_SLOTS - 1));
  assign wr_prio     = PRIO_BITS'(cmd.prio_value);

  // Round-robin scan starts after the current slot; past the end, wrap to 1.
  always_comb begin
    start_wide = current_valid ? ({1'b0, current_env} + (SLOT_W+1)'(1)) : (SLOT_W+1)'(1);
    if (start_wide >= (SLOT_W+1)'(NUM_SLOTS) || start_wide == '0) begin
      start_idx = SLOT_W'(1);
    end else begin
      start_idx = start_wide[SLOT_W-1:0];
    end
  end

  // Ring of slot cells: cell i loads from cell i+1, so the head (cell 0)
  // shows slot k after k shifts and every slot is home after a full turn.
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    localparam int NXT = (i + 1) % NUM_SLOTS;
    logic wr_hit;
    assign wr_hit = take_status && ({26'b0, cmd.env_index} == 32'(i));

    rrsched_cell #(
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (shift_en),
      .wr_en    (wr_hit),
      .wr_run   (cmd.runnable),
      .wr_prio  (wr_prio),
      .nbr_run  (cell_run[NXT]),
      .nbr_prio (cell_prio[NXT]),
      .run      (cell_run[i]),
      .prio     (cell_prio[i])
    );
  end

  rrsched_scan #(
    .SLOT_W    (SLOT_W),
    .PRIO_BITS (PRIO_BITS)
  ) u_scan (
    .clk       (clk),
    .en        (scan_en),
    .policy    (sched_policy),
    .start_idx (start_idx),
    .slot_idx  (slot_cnt),
    .head_run  (cell_run[0]),
    .head_prio (cell_prio[0]),
    .pick      (pick),
    .idle_ok   (idle_ok)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take_yield) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_slot) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    busy     = 1'b0;
    shift_en = 1'b0;
    scan_en  = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_SCAN: begin
        busy     = 1'b1;
        shift_en = 1'b1;
        scan_en  = 1'b1;
      end
      ST_FINISH: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_cnt      <= '0;
      current_env   <= '0;
      current_valid <= 1'b0;
      sched_policy  <= POLICY_RR;
      result_valid  <= 1'b0;
      result        <= '0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (cfg_we) begin
        sched_policy <= cfg_wdata;
      end
      // Advance the slot count with the ring; clear it for the next yield.
      if (take_yield) begin
        slot_cnt <= '0;
      end else if (shift_en) begin
        slot_cnt <= last_slot ? '0 : slot_cnt + SLOT_W'(1);
      end
      // Settle the pick: normal slot, else idle slot 0, else halt.
      if (state == ST_FINISH) begin
        result_valid <= 1'b1;
        if (pick != '0) begin
          current_env       <= pick;
          current_valid     <= 1'b1;
          result.chosen_env <= ENV_W'(pick);
          result.outcome    <= OUT_NORMAL;
        end else if (idle_ok) begin
          current_env       <= '0;
          current_valid     <= 1'b1;
          result.chosen_env <= '0;
          result.outcome    <= OUT_IDLE;
        end else begin
          current_env       <= '0;
          current_valid     <= 1'b0;
          result.chosen_env <= '0;
          result.outcome    <= OUT_HALT;
        end
      end
    end
  end

endmodule

// File: hw/rtl/rrsched_checker.sv
module rrsched_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input rrsched_pkg::cmd_t    cmd,
  input logic                 result_valid,
  input rrsched_pkg::result_t result
);
  import rrsched_pkg::*;

  // A taken yield raises busy.
  a_yield_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.mode == MODE_YIELD |=> busy)
    else $error("yield taken but busy not raised");

  // A status write leaves busy low and produces no result beat.
  a_status_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.mode == MODE_STATUS |=> !busy && !result_valid)
    else $error("status write caused busy or a result beat");

  // Result beats are single cycles, never back to back.
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result beat lasted more than one cycle");

  // Idle and halt beats carry slot 0; no other outcome code appears.
  a_outcome: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.outcome == OUT_NORMAL && result.chosen_env != '0) ||
                     ((result.outcome == OUT_IDLE || result.outcome == OUT_HALT) &&
                      result.chosen_env == '0))
    else $error("bad outcome or slot in result beat");

endmodule

bind round_robin_env_scheduler rrsched_checker u_rrsched_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .cmd          (cmd),
  .result_valid (result_valid),
  .result       (result)
);
